>>> hw/rtl/crt_pkg.sv
// Shared types and constants of the contour resample threshold block.
`timescale 1ns / 1ps

package crt_pkg;

  // Input item opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BIN   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_RATIO     = 2'd0;
  localparam logic [1:0] REG_LENGTH    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // Configuration reset values.
  localparam logic [23:0] RATIO_RESET     = 24'd81920;
  localparam logic [10:0] LENGTH_RESET    = 11'd640;
  localparam logic [23:0] THRESHOLD_RESET = 24'd3276800;

  // Trigger codes.
  localparam logic [1:0] TRIG_STAY  = 2'd0;
  localparam logic [1:0] TRIG_ENTER = 2'd1;
  localparam logic [1:0] TRIG_EXIT  = 2'd2;

  // Contour value after reset, -1.0 in Q1.15.
  localparam logic signed [15:0] SAMPLE_RESET = 16'sh8000;

  // Saturation level of the gain sum.
  localparam logic [23:0] SUM_MAX = 24'hFFFFFF;

  // One input beat.
  typedef struct packed {
    logic              opcode;
    logic [9:0]        sample_index;
    logic signed [15:0] sample_value;
    logic [8:0]        bin_index;
    logic              last_bin;
  } crt_in_t;

  // One result beat.
  typedef struct packed {
    logic [14:0] gain;
    logic        trigger_valid;
    logic [1:0]  trigger;
  } crt_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic [23:0] ratio_q16;
    logic [10:0] contour_length;
    logic [23:0] enter_threshold;
  } crt_cfg_t;

  // Phase strobes from the sequencer to the resampling datapath.
  typedef struct packed {
    logic load;
    logic addr;
    logic mul;
    logic acc;
  } crt_ctl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_MUL,
    ST_ACC
  } crt_state_e;

endpackage

>>> hw/rtl/crt_cfg_regs.sv
// Configuration register file of the contour resample threshold block.
`timescale 1ns / 1ps

module crt_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i,
  output crt_pkg::crt_cfg_t cfg_o
);

  crt_pkg::crt_cfg_t cfg_q, cfg_d;

  // Registers are always ready to take a write beat.
  assign cfg_ready_o = 1'b1;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        crt_pkg::REG_RATIO:     cfg_d.ratio_q16       = cfg_data_i;
        crt_pkg::REG_LENGTH:    cfg_d.contour_length  = cfg_data_i[10:0];
        crt_pkg::REG_THRESHOLD: cfg_d.enter_threshold = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio_q16       <= crt_pkg::RATIO_RESET;
      cfg_q.contour_length  <= crt_pkg::LENGTH_RESET;
      cfg_q.enter_threshold <= crt_pkg::THRESHOLD_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/crt_contour_mem.sv
// Contour sample memory with one write port and two registered read ports.
`timescale 1ns / 1ps

module crt_contour_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [AddrW-1:0]        waddr_i,
  input  logic signed [15:0]      wdata_i,
  input  logic                    re_i,
  input  logic [AddrW-1:0]        raddr_a_i,
  input  logic [AddrW-1:0]        raddr_b_i,
  output logic signed [15:0]      rdata_a_o,
  output logic signed [15:0]      rdata_b_o
);

  logic signed [15:0] mem_q [DEPTH];
  logic signed [15:0] rdata_a_q;
  logic signed [15:0] rdata_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports; read data shows in the cycle after re_i.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hw/rtl/crt_resample.sv
// Resampling datapath: position, neighbor reads, interpolation, gain sum and trigger.
`timescale 1ns / 1ps

module crt_resample #(
  parameter int unsigned MAX_CONTOUR = 1024,
  parameter int unsigned NUM_BINS    = 512,
  parameter int unsigned AddrW       = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crt_pkg::crt_ctl_t  ctl_i,
  input  crt_pkg::crt_cfg_t  cfg_i,
  input  logic [8:0]         bin_index_i,
  input  logic               last_bin_i,
  output logic               re_o,
  output logic [AddrW-1:0]   raddr_a_o,
  output logic [AddrW-1:0]   raddr_b_o,
  input  logic signed [15:0] rdata_a_i,
  input  logic signed [15:0] rdata_b_i,
  output logic               result_valid_o,
  output crt_pkg::crt_out_t  result_o
);

  // Item registers.
  logic [32:0]        pos_q;
  logic [32:0]        pos_d;
  logic               bin_ok_q;
  logic               last_q;
  logic [15:0]        w_q;
  logic signed [15:0] a_q;
  logic signed [33:0] prod_q;

  // Frame state.
  logic [23:0]        sum_q, sum_d;
  logic               status_q, status_d;

  // Result registers.
  logic               result_valid_q;
  crt_pkg::crt_out_t  result_q, result_d;

  // Address phase signals.
  logic [31:0]        len_w;
  logic [31:0]        n_w;
  logic [31:0]        last_w;
  logic [31:0]        idx_w;
  logic [AddrW-1:0]   last_addr;
  logic               at_end;

  // Multiply and accumulate phase signals.
  logic signed [16:0] a_ext;
  logic signed [16:0] b_ext;
  logic signed [16:0] diff;
  logic signed [16:0] w_ext;
  logic signed [33:0] prod_d;
  logic signed [34:0] rnd;
  logic signed [18:0] delta;
  logic signed [18:0] height;
  logic signed [18:0] biased;
  logic [14:0]        gain;
  logic [24:0]        sum_ext;
  logic [23:0]        sum_sat;
  logic               status_now;

  // Sample position of the bin, Q.16.
  assign pos_d = {24'd0, bin_index_i} * {9'd0, cfg_i.ratio_q16};

  // Length in use, saturated to 1..MAX_CONTOUR, and its last address.
  always_comb begin
    len_w = 32'(cfg_i.contour_length);
    if (len_w == 32'd0) begin
      n_w = 32'd1;
    end else if (len_w > 32'(MAX_CONTOUR)) begin
      n_w = 32'(MAX_CONTOUR);
    end else begin
      n_w = len_w;
    end
    last_w    = n_w - 32'd1;
    last_addr = last_w[AddrW-1:0];
  end

  // Neighbor addresses; past the end both point at the last sample.
  assign idx_w     = 32'(pos_q[32:16]);
  assign at_end    = idx_w >= last_w;
  assign re_o      = ctl_i.addr;
  assign raddr_a_o = at_end ? last_addr : idx_w[AddrW-1:0];
  assign raddr_b_o = at_end ? last_addr : idx_w[AddrW-1:0] + AddrW'(1);

  // Difference of the neighbors times the fractional weight.
  assign a_ext  = {rdata_a_i[15], rdata_a_i};
  assign b_ext  = {rdata_b_i[15], rdata_b_i};
  assign diff   = b_ext - a_ext;
  assign w_ext  = $signed({1'b0, w_q});
  assign prod_d = diff * w_ext;

  // Round to nearest, halves upward, then map the height to a gain.
  always_comb begin
    rnd     = {prod_q[33], prod_q} + 35'sd32768;
    delta   = rnd[34:16];
    height  = {{3{a_q[15]}}, a_q} + delta;
    biased  = height + 19'sd32768;
    gain    = bin_ok_q ? biased[15:1] : 15'd0;
    sum_ext = {1'b0, sum_q} + {10'd0, gain};
    sum_sat = sum_ext[24] ? crt_pkg::SUM_MAX : sum_ext[23:0];
  end

  // Frame decision on the last bin.
  always_comb begin
    status_now             = sum_sat > cfg_i.enter_threshold;
    sum_d                  = sum_q;
    status_d               = status_q;
    result_d.gain          = gain;
    result_d.trigger_valid = last_q;
    result_d.trigger       = crt_pkg::TRIG_STAY;
    if (ctl_i.acc) begin
      if (last_q) begin
        sum_d    = 24'd0;
        status_d = status_now;
        if (status_now != status_q) begin
          result_d.trigger = status_now ? crt_pkg::TRIG_ENTER : crt_pkg::TRIG_EXIT;
        end
      end else begin
        sum_d = sum_sat;
      end
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      pos_q    <= pos_d;
      bin_ok_q <= 32'(bin_index_i) < 32'(NUM_BINS);
      last_q   <= last_bin_i;
    end
    if (ctl_i.addr) begin
      w_q <= at_end ? 16'd0 : pos_q[15:0];
    end
    if (ctl_i.mul) begin
      a_q    <= rdata_a_i;
      prod_q <= prod_d;
    end
    if (ctl_i.acc) begin
      result_q <= result_d;
    end
  end

  // Frame state and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q          <= 24'd0;
      status_q       <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      sum_q          <= sum_d;
      status_q       <= status_d;
      result_valid_q <= ctl_i.acc;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // A trigger is only reported on a beat that closes a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_q && !result_q.trigger_valid) |-> (result_q.trigger == crt_pkg::TRIG_STAY))
    else $error("trigger without frame close");

  // The sum is cleared after every frame close.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.acc && last_q) |=> (sum_q == 24'd0))
    else $error("gain sum not cleared at frame close");

endmodule

>>> hw/rtl/contour_resample_threshold_top.sv
// Top level of the contour resample threshold block: sequencer, clearing sweep and wiring.
// A bin item passes the read, multiply and accumulate steps, which end in the output register;
// a write item is written to the contour memory at the accepting edge and gives no result.
// A bin item keeps busy high until it is done; write items are taken one every cycle while idle.
// Reset: sequencer, frame and config registers clear at once, then a sweep writes -1.0 to
// every contour entry, one a cycle, with busy high; configuration writes are taken meanwhile.
// Each result beat is shown for one cycle with result_valid_o; the receiver cannot stall.
`timescale 1ns / 1ps

module contour_resample_threshold_top #(
  parameter int unsigned MAX_CONTOUR = 1024,
  parameter int unsigned NUM_BINS    = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  crt_pkg::crt_in_t  in_i,
  output logic              result_valid_o,
  output crt_pkg::crt_out_t result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [23:0]       cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_CONTOUR);

  crt_pkg::crt_state_e state_q, state_d;
  crt_pkg::crt_cfg_t   cfg;
  crt_pkg::crt_ctl_t   ctl;

  logic [AddrW-1:0]    clr_cnt_q, clr_cnt_d;
  logic                accept;
  logic                sample_ok;
  logic [31:0]         sidx_w;

  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  logic signed [15:0]  mem_wdata;
  logic                mem_re;
  logic [AddrW-1:0]    mem_raddr_a;
  logic [AddrW-1:0]    mem_raddr_b;
  logic signed [15:0]  mem_rdata_a;
  logic signed [15:0]  mem_rdata_b;

  assign accept    = start && !busy;
  assign sidx_w    = 32'(in_i.sample_index);
  assign sample_ok = sidx_w < 32'(MAX_CONTOUR);

  // Next state: the memory is only accessed by one item at a time, so reads never meet a write.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      crt_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == AddrW'(MAX_CONTOUR - 1)) begin
          state_d = crt_pkg::ST_IDLE;
        end
      end
      crt_pkg::ST_IDLE: begin
        if (accept && in_i.opcode == crt_pkg::OP_BIN) begin
          state_d = crt_pkg::ST_ADDR;
        end
      end
      crt_pkg::ST_ADDR: state_d = crt_pkg::ST_MUL;
      crt_pkg::ST_MUL:  state_d = crt_pkg::ST_ACC;
      crt_pkg::ST_ACC:  state_d = crt_pkg::ST_IDLE;
      default:          state_d = crt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: busy, phase strobes and the memory write port.
  always_comb begin
    busy      = 1'b1;
    ctl       = '0;
    mem_we    = 1'b0;
    mem_waddr = sidx_w[AddrW-1:0];
    mem_wdata = in_i.sample_value;
    unique case (state_q)
      crt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = crt_pkg::SAMPLE_RESET;
      end
      crt_pkg::ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start && in_i.opcode == crt_pkg::OP_BIN;
        mem_we   = start && in_i.opcode == crt_pkg::OP_WRITE && sample_ok;
      end
      crt_pkg::ST_ADDR: ctl.addr = 1'b1;
      crt_pkg::ST_MUL:  ctl.mul  = 1'b1;
      crt_pkg::ST_ACC:  ctl.acc  = 1'b1;
      default:          busy     = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= crt_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // Configuration registers.
  crt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Contour store.
  crt_contour_mem #(
    .DEPTH (MAX_CONTOUR),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .re_i      (mem_re),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // Resampling datapath.
  crt_resample #(
    .MAX_CONTOUR (MAX_CONTOUR),
    .NUM_BINS    (NUM_BINS),
    .AddrW       (AddrW)
  ) u_resample (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .cfg_i          (cfg),
    .bin_index_i    (in_i.bin_index),
    .last_bin_i     (in_i.last_bin),
    .re_o           (mem_re),
    .raddr_a_o      (mem_raddr_a),
    .raddr_b_o      (mem_raddr_b),
    .rdata_a_i      (mem_rdata_a),
    .rdata_b_i      (mem_rdata_b),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // A result beat only follows the accumulate step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == crt_pkg::ST_ACC))
    else $error("result beat outside accumulate step");

  // The memory is never written while a bin item is reading it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == crt_pkg::ST_ADDR || state_q == crt_pkg::ST_MUL || state_q == crt_pkg::ST_ACC)
      |-> !mem_we)
    else $error("contour write during bin item");

  // Every accepted bin item gives its result beat after its address, multiply and accumulate steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.opcode == crt_pkg::OP_BIN) |-> ##4 result_valid_o)
    else $error("bin item result missing");

endmodule
